[hw/rtl/pty_pkg.sv]
// ----------------------------------------------------------------------------
// pty_pkg
// Shared types and constants for the pixel to YCbCr converter pipeline.
// ----------------------------------------------------------------------------
package pty_pkg;

    localparam int BYTE_W      = 8;
    localparam int DATA_W      = 3 * BYTE_W;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int FMT_W       = 2;
    localparam int LUMA_W      = 23;
    localparam int CHROMA_W    = 18;
    localparam int SHIFTED_W   = 9;
    localparam int FRAC_LUMA   = 14;
    localparam int FRAC_CHROMA = 9;

    localparam logic [0:0] REG_INPUT_FORMAT = 1'b0;

    typedef enum logic [FMT_W-1:0] {
        FMT_RGB888 = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_YCC    = 2'd2
    } fmt_t;

    localparam logic signed [LUMA_W-1:0] Y_R = 23'sd4898;
    localparam logic signed [LUMA_W-1:0] Y_G = 23'sd9610;
    localparam logic signed [LUMA_W-1:0] Y_B = 23'sd1868;

    localparam logic signed [CHROMA_W-1:0] CB_B = 18'sd256;
    localparam logic signed [CHROMA_W-1:0] CB_R = 18'sd86;
    localparam logic signed [CHROMA_W-1:0] CB_G = 18'sd169;
    localparam logic signed [CHROMA_W-1:0] CR_R = 18'sd256;
    localparam logic signed [CHROMA_W-1:0] CR_G = 18'sd214;
    localparam logic signed [CHROMA_W-1:0] CR_B = 18'sd42;

    typedef struct packed {
        logic                     pass;
        logic signed [BYTE_W-1:0] rc;
        logic signed [BYTE_W-1:0] gc;
        logic signed [BYTE_W-1:0] bc;
    } cent_t;

    typedef struct packed {
        cent_t                      cent;
        logic signed [LUMA_W-1:0]   y_r;
        logic signed [LUMA_W-1:0]   y_g;
        logic signed [LUMA_W-1:0]   y_b;
        logic signed [CHROMA_W-1:0] cb_b;
        logic signed [CHROMA_W-1:0] cb_r;
        logic signed [CHROMA_W-1:0] cb_g;
        logic signed [CHROMA_W-1:0] cr_r;
        logic signed [CHROMA_W-1:0] cr_g;
        logic signed [CHROMA_W-1:0] cr_b;
    } prod_t;

    typedef struct packed {
        cent_t                      cent;
        logic signed [LUMA_W-1:0]   y;
        logic signed [CHROMA_W-1:0] cb;
        logic signed [CHROMA_W-1:0] cr;
    } sum_t;

endpackage

[hw/rtl/pty_unpack.sv]
// ----------------------------------------------------------------------------
// pty_unpack
// First pipeline stage: reads the input bytes by format and centers them.
// ----------------------------------------------------------------------------
module pty_unpack
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [pty_pkg::FMT_W-1:0]     fmt,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pty_pkg::DATA_W-1:0]    in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pty_pkg::cent_t                out_data
);

    logic                         valid_reg;
    pty_pkg::cent_t               data_reg;
    pty_pkg::cent_t               data_next;
    logic [pty_pkg::BYTE_W-1:0]   b0;
    logic [pty_pkg::BYTE_W-1:0]   b1;
    logic [pty_pkg::BYTE_W-1:0]   b2;
    logic [pty_pkg::BYTE_W-1:0]   r;
    logic [pty_pkg::BYTE_W-1:0]   g;
    logic [pty_pkg::BYTE_W-1:0]   b;
    logic [4:0]                   r5;
    logic [5:0]                   g6;
    logic [4:0]                   b5;

    assign b0 = in_data[7:0];
    assign b1 = in_data[15:8];
    assign b2 = in_data[23:16];

    assign r5 = b1[7:3];
    assign g6 = {b1[2:0], b0[7:5]};
    assign b5 = b0[4:0];

    always_comb
    begin
        data_next.pass = 1'b0;
        r = b0;
        g = b1;
        b = b2;
        unique case (fmt)
            pty_pkg::FMT_RGB565:
            begin
                r = {r5, r5[4:2]};
                g = {g6, g6[5:4]};
                b = {b5, b5[4:2]};
            end
            pty_pkg::FMT_YCC:
            begin
                data_next.pass = 1'b1;
            end
            default:
            begin
                r = b0;
                g = b1;
                b = b2;
            end
        endcase
        data_next.rc = {~r[7], r[6:0]};
        data_next.gc = {~g[7], g[6:0]};
        data_next.bc = {~b[7], b[6:0]};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/pty_mac.sv]
// ----------------------------------------------------------------------------
// pty_mac
// Second and third pipeline stages: weighted products, then their sums.
// ----------------------------------------------------------------------------
module pty_mac
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  pty_pkg::cent_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pty_pkg::sum_t  out_data
);

    logic                                 prod_valid_reg;
    logic                                 prod_ready;
    pty_pkg::prod_t                       prod_reg;
    pty_pkg::prod_t                       prod_next;
    logic                                 sum_valid_reg;
    pty_pkg::sum_t                        sum_reg;
    pty_pkg::sum_t                        sum_next;
    logic signed [pty_pkg::LUMA_W-1:0]    rc_l;
    logic signed [pty_pkg::LUMA_W-1:0]    gc_l;
    logic signed [pty_pkg::LUMA_W-1:0]    bc_l;
    logic signed [pty_pkg::CHROMA_W-1:0]  rc_c;
    logic signed [pty_pkg::CHROMA_W-1:0]  gc_c;
    logic signed [pty_pkg::CHROMA_W-1:0]  bc_c;

    assign rc_l = pty_pkg::LUMA_W'(in_data.rc);
    assign gc_l = pty_pkg::LUMA_W'(in_data.gc);
    assign bc_l = pty_pkg::LUMA_W'(in_data.bc);
    assign rc_c = pty_pkg::CHROMA_W'(in_data.rc);
    assign gc_c = pty_pkg::CHROMA_W'(in_data.gc);
    assign bc_c = pty_pkg::CHROMA_W'(in_data.bc);

    always_comb
    begin
        prod_next.cent = in_data;
        prod_next.y_r  = rc_l * pty_pkg::Y_R;
        prod_next.y_g  = gc_l * pty_pkg::Y_G;
        prod_next.y_b  = bc_l * pty_pkg::Y_B;
        prod_next.cb_b = bc_c * pty_pkg::CB_B;
        prod_next.cb_r = rc_c * pty_pkg::CB_R;
        prod_next.cb_g = gc_c * pty_pkg::CB_G;
        prod_next.cr_r = rc_c * pty_pkg::CR_R;
        prod_next.cr_g = gc_c * pty_pkg::CR_G;
        prod_next.cr_b = bc_c * pty_pkg::CR_B;
    end

    always_comb
    begin
        sum_next.cent = prod_reg.cent;
        sum_next.y    = prod_reg.y_r + prod_reg.y_g + prod_reg.y_b;
        sum_next.cb   = prod_reg.cb_b - prod_reg.cb_r - prod_reg.cb_g;
        sum_next.cr   = prod_reg.cr_r - prod_reg.cr_g - prod_reg.cr_b;
    end

    assign prod_ready = !sum_valid_reg || out_ready;
    assign in_ready   = !prod_valid_reg || prod_ready;
    assign out_valid  = sum_valid_reg;
    assign out_data   = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                prod_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                sum_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (prod_ready && prod_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

[hw/rtl/pty_saturate.sv]
// ----------------------------------------------------------------------------
// pty_saturate
// Last stage: drops fraction bits, saturates (or passes YCC), holds output.
// ----------------------------------------------------------------------------
module pty_saturate
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pty_pkg::sum_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pty_pkg::DATA_W-1:0]  out_data
);

    logic                                  valid_reg;
    logic [pty_pkg::DATA_W-1:0]            data_reg;
    logic [pty_pkg::DATA_W-1:0]            data_next;
    logic signed [pty_pkg::SHIFTED_W-1:0]  y_shift;
    logic signed [pty_pkg::SHIFTED_W-1:0]  cb_shift;
    logic signed [pty_pkg::SHIFTED_W-1:0]  cr_shift;

    function automatic logic [pty_pkg::BYTE_W-1:0] clamp_byte
    (
        input logic signed [pty_pkg::SHIFTED_W-1:0] v
    );
        logic [pty_pkg::BYTE_W-1:0] res;
        priority if (v > 9'sd127)
        begin
            res = 8'h7F;
        end
        else if (v < -9'sd128)
        begin
            res = 8'h80;
        end
        else
        begin
            res = v[pty_pkg::BYTE_W-1:0];
        end
        return res;
    endfunction

    assign y_shift  = pty_pkg::SHIFTED_W'(in_data.y >>> pty_pkg::FRAC_LUMA);
    assign cb_shift = pty_pkg::SHIFTED_W'(in_data.cb >>> pty_pkg::FRAC_CHROMA);
    assign cr_shift = pty_pkg::SHIFTED_W'(in_data.cr >>> pty_pkg::FRAC_CHROMA);

    always_comb
    begin
        if (in_data.cent.pass)
        begin
            data_next = {in_data.cent.bc, in_data.cent.gc, in_data.cent.rc};
        end
        else
        begin
            data_next = {clamp_byte(cr_shift), clamp_byte(cb_shift), clamp_byte(y_shift)};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[hw/rtl/pixel_to_ycbcr_converter.sv]
// Each accepted item passes the unpack, product, sum and saturate registers.
// Throughput: one item per cycle; each of the four stage registers advances
// whenever the stage after it is empty or is handing its item on.
// Reset: rst_n clears all stage valid bits and sets input_format to RGB888.
// ----------------------------------------------------------------------------
// pixel_to_ycbcr_converter
// Converts one pixel per item to level-shifted YCbCr samples, with an APB
// register that selects the input format.
// ----------------------------------------------------------------------------
module pixel_to_ycbcr_converter
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pty_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [pty_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pty_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0 up: byte_zero, byte_one, byte_two.
    input  logic [pty_pkg::DATA_W-1:0]       s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0 up: luma, blue_diff, red_diff.
    output logic [pty_pkg::DATA_W-1:0]       m_tdata
);

    logic [pty_pkg::FMT_W-1:0] fmt_reg;
    logic                      cfg_write;
    logic                      cent_valid;
    logic                      cent_ready;
    pty_pkg::cent_t            cent_data;
    logic                      sum_valid;
    logic                      sum_ready;
    pty_pkg::sum_t             sum_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == pty_pkg::REG_INPUT_FORMAT);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == pty_pkg::REG_INPUT_FORMAT)
        begin
            prdata = pty_pkg::APB_DATA_W'(fmt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= pty_pkg::FMT_RGB888;
        end
        else if (cfg_write)
        begin
            fmt_reg <= pwdata[pty_pkg::FMT_W-1:0];
        end
    end

    pty_unpack u_unpack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt       (fmt_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (cent_valid),
        .out_ready (cent_ready),
        .out_data  (cent_data)
    );

    pty_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cent_valid),
        .in_ready  (cent_ready),
        .in_data   (cent_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_data)
    );

    pty_saturate u_saturate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

[hw/rtl/pty_checker.sv]
// ----------------------------------------------------------------------------
// pty_checker
// Port-level checks on the converter's streaming channels.
// ----------------------------------------------------------------------------
module pty_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [pty_pkg::DATA_W-1:0]  m_tdata
);

    // A stalled result holds its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output item changed or dropped");

    // With the output side ready, every stage can advance, so input is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
    else $error("input stalled while output side ready");

    // A result that appears on an empty output comes from an item taken
    // earlier through the unpack, product, sum and saturate registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
    else $error("output item appeared without matching input item");

endmodule

bind pixel_to_ycbcr_converter pty_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[test/pixel_to_ycbcr_converter_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_to_ycbcr_converter_checker
// Watches the register port and both pixel streams of the converter. For
// every accepted pixel it works out the level-shifted YCbCr sample for the
// current input format and queues it. Each sample leaving the block is then
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module pixel_to_ycbcr_converter_checker
    import pty_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_W-1:0]     m_tdata,
    output int                    mismatch_count,
    output int                    samples_checked,
    output int                    samples_waiting
);

    typedef struct packed {
        logic signed [BYTE_W-1:0] red_diff;
        logic signed [BYTE_W-1:0] blue_diff;
        logic signed [BYTE_W-1:0] luma;
    } ycc_sample_t;

    typedef struct {
        logic [DATA_W-1:0] pixel;
        logic [FMT_W-1:0]  format;
        ycc_sample_t       sample;
    } expected_sample_t;

    logic [FMT_W-1:0]  active_format;
    expected_sample_t  expected_samples [$];

    function automatic logic [BYTE_W-1:0] saturate_sample(input int value);
        if (value < -128)
            return 8'h80;
        if (value > 127)
            return 8'h7F;
        return value[BYTE_W-1:0];
    endfunction

    function automatic ycc_sample_t convert_pixel(input logic [FMT_W-1:0] format,
                                                  input logic [DATA_W-1:0] pixel);
        logic [BYTE_W-1:0] byte_zero;
        logic [BYTE_W-1:0] byte_one;
        logic [BYTE_W-1:0] byte_two;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [15:0]       word;
        int                rc;
        int                gc;
        int                bc;
        ycc_sample_t       sample;
        byte_zero = pixel[7:0];
        byte_one  = pixel[15:8];
        byte_two  = pixel[23:16];
        if (format == FMT_YCC)
        begin
            sample.luma      = byte_zero - 8'd128;
            sample.blue_diff = byte_one - 8'd128;
            sample.red_diff  = byte_two - 8'd128;
            return sample;
        end
        if (format == FMT_RGB565)
        begin
            // Each channel is widened by repeating its top bits below it.
            word  = {byte_one, byte_zero};
            red   = {word[15:11], word[15:13]};
            green = {word[10:5], word[10:9]};
            blue  = {word[4:0], word[4:2]};
        end
        else
        begin
            red   = byte_zero;
            green = byte_one;
            blue  = byte_two;
        end
        rc = int'(red);
        gc = int'(green);
        bc = int'(blue);
        rc = rc - 128;
        gc = gc - 128;
        bc = bc - 128;
        sample.luma      = saturate_sample((4898 * rc + 9610 * gc + 1868 * bc) >>> 14);
        sample.blue_diff = saturate_sample((256 * bc - 86 * rc - 169 * gc) >>> 9);
        sample.red_diff  = saturate_sample((256 * rc - 214 * gc - 42 * bc) >>> 9);
        return sample;
    endfunction

    task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got, input expected_sample_t entry);
        if (want !== got)
        begin
            if (mismatch_count < 10)
                $display("%0t: %s wrong for pixel %h in format %0d: expected %0d, got %0d",
                         $time, field, entry.pixel, entry.format, $signed(want),
                         $signed(got));
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        expected_sample_t entry;
        ycc_sample_t      got;
        if (!rst_n)
        begin
            active_format <= FMT_RGB888;
            expected_samples.delete();
            samples_waiting <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00
                && paddr[APB_ADDR_W-1:2] == REG_INPUT_FORMAT)
                active_format <= pwdata[FMT_W-1:0];
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_samples.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: sample %h arrived with none expected", $time, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    entry = expected_samples.pop_front();
                    check_field("luma", entry.sample.luma, got.luma, entry);
                    check_field("blue_diff", entry.sample.blue_diff, got.blue_diff, entry);
                    check_field("red_diff", entry.sample.red_diff, got.red_diff, entry);
                    samples_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                entry.pixel  = s_tdata;
                entry.format = active_format;
                entry.sample = convert_pixel(active_format, s_tdata);
                expected_samples.push_back(entry);
            end
            samples_waiting <= expected_samples.size();
        end
    end

endmodule

[test/pixel_to_ycbcr_converter_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_to_ycbcr_converter_test
// Drives the converter with directed corner pixels in every input format and
// then with random pixels over several format settings, with bursty input,
// a stalling output and long output hold-offs. A separate checker predicts
// and compares every sample; this module decides the verdict.
// ----------------------------------------------------------------------------
module pixel_to_ycbcr_converter_test;

    import pty_pkg::*;

    localparam int                    CYCLE_LIMIT  = 200000;
    localparam int                    HOLD_CYCLES  = 90;
    localparam int                    PHASE_PIXELS = 64;
    localparam logic [FMT_W-1:0]      FMT_RESERVED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] FORMAT_ADDR  = {REG_INPUT_FORMAT, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR   = 3'd4;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // Fields from bit 0 up: byte_zero, byte_one, byte_two.
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // Fields from bit 0 up: luma, blue_diff, red_diff.
    logic [DATA_W-1:0]     m_tdata;

    int mismatch_count;
    int samples_checked;
    int samples_waiting;
    int hold_requests = 0;
    int config_writes = 0;
    int cycle_count = 0;

    pixel_to_ycbcr_converter i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pixel_to_ycbcr_converter_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .samples_checked (samples_checked),
        .samples_waiting (samples_waiting)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_writes++;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [BYTE_W-1:0] byte_zero,
                              input logic [BYTE_W-1:0] byte_one,
                              input logic [BYTE_W-1:0] byte_two);
        s_tvalid <= 1'b1;
        s_tdata  <= {byte_two, byte_one, byte_zero};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (samples_waiting != 0)
            @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_byte();
        if ($urandom_range(0, 3) != 0)
            return BYTE_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            default: return 8'h80;
        endcase
    endfunction

    initial
    begin
        forever
        begin : output_stalls
            int stall_mode;
            int holds_done;
            int mode_cycles;
            stall_mode  = 0;
            holds_done  = 0;
            mode_cycles = 0;
            forever
            begin
                @(posedge clk);
                if (hold_requests > holds_done)
                begin
                    holds_done++;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES)
                        @(posedge clk);
                end
                mode_cycles++;
                if (mode_cycles % 48 == 0)
                    stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (mode_cycles % 5 < 2);
                endcase
            end
        end
    end

    initial
    begin : pixel_stimulus
        logic [FMT_W-1:0]      phase_formats [0:6];
        logic [APB_DATA_W-1:0] value;
        int                    sent;
        int                    burst;
        int                    gap;
        int                    gap_max;
        phase_formats = '{FMT_RGB888, FMT_RGB565, FMT_YCC, FMT_RESERVED,
                          FMT_RGB565, FMT_RGB888, FMT_YCC};
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_register(FORMAT_ADDR, {30'd0, FMT_RGB888});
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'h80, 8'h80, 8'h80);
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        drain_pipeline();

        // Byte two must have no effect in this format.
        write_register(FORMAT_ADDR, {30'd0, FMT_RGB565});
        send_pixel(8'h00, 8'h00, 8'hFF);
        send_pixel(8'hFF, 8'hFF, 8'h00);
        send_pixel(8'h00, 8'hF8, 8'h5A);
        send_pixel(8'hE0, 8'h07, 8'hA5);
        send_pixel(8'h1F, 8'h00, 8'hFF);
        send_pixel(8'h55, 8'hAA, 8'h00);
        drain_pipeline();

        write_register(FORMAT_ADDR, {30'd0, FMT_YCC});
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'h80, 8'h7F, 8'h81);
        drain_pipeline();

        // A write to an address with no register behind it changes nothing.
        write_register(SPARE_ADDR, {30'd0, FMT_RGB888});
        send_pixel(8'h12, 8'hED, 8'h80);
        send_pixel(8'hFF, 8'h00, 8'h7F);
        drain_pipeline();

        // The reserved code behaves as rgb888; upper data bits are dropped.
        write_register(FORMAT_ADDR, {30'h2AAA_AAAA, FMT_RESERVED});
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'h80);
        drain_pipeline();

        for (int phase = 0; phase < 7; phase++)
        begin
            if ($urandom_range(0, 2) == 0)
                write_register(SPARE_ADDR, $urandom);
            value = ($urandom_range(0, 1) != 0) ? $urandom : '0;
            value[FMT_W-1:0] = phase_formats[phase];
            write_register(FORMAT_ADDR, value);
            gap_max = (phase % 3) * 3;
            sent = 0;
            while (sent < PHASE_PIXELS)
            begin
                burst = $urandom_range(1, 16);
                if (sent == 0 && (phase == 1 || phase == 4))
                begin
                    hold_requests <= hold_requests + 1;
                    burst = 40;
                end
                for (int k = 0; k < burst && sent < PHASE_PIXELS; k++)
                begin
                    send_pixel(pick_byte(), pick_byte(), pick_byte());
                    sent++;
                end
                gap = $urandom_range(0, gap_max);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap)
                        @(posedge clk);
                end
            end
            drain_pipeline();
        end

        repeat (8)
            @(posedge clk);
        $display("Checked %0d converted pixels over %0d register writes.",
                 samples_checked, config_writes);
        $display("Covered rgb888, rgb565, pass-through and the reserved code, %0d hold-offs.",
                 hold_requests);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
